### rtl/vcs_pkg.sv
// Package for the victim buffer: sizes, result codes and the lookup record.
// No dependencies; every other file of the block imports it.
package vcs_pkg;

	localparam int ENTRIES = 8;
	localparam int WAY_W   = $clog2(ENTRIES);
	localparam int ADDR_W  = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WAY_W-1:0]  way_t;

	typedef enum logic [1:0] {
		KIND_HIT       = 2'd0,
		KIND_MISS      = 2'd1,
		KIND_WRITEBACK = 2'd2
	} kind_t;

	// Outcome of one lookup: which way to rewrite and what goes back out.
	typedef struct packed {
		way_t  way;
		kind_t kind;
		addr_t ret_addr;
		logic  ret_dirty;
	} lookup_t;

endpackage

### rtl/victim_cache_swap.sv
// Victim buffer top level: input register, lookup and entry update, result register.
// Depends on vcs_pkg, vcs_lookup and vcs_entries.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: the block address
//   the main cache is looking for and the block it is evicting with its dirty mark.
//   Output channel (out_valid/out_ready) returns exactly one item per request:
//   hit with the swapped-out block, miss, or miss with a dirty block to write back.
//   Path: an accepted item is captured in the input register; its lookup result is then
//   captured in the result register, which drives out_valid.
//   Throughput: one item per cycle while out_ready does not stall; the lookup over all
//   eight entries, the LRU select and the entry/age update all happen between the
//   input register and the result register, so each item sees the state left by
//   the one before it.
//   Stall: while out_ready is low the result register holds; one more item waits in
//   the input register, then in_ready drops until the result is taken.
//   Reset: arst_n clears all valid and dirty marks and restores the LRU order to the
//   entry index; no clearing pass is needed, so items are taken right after reset.
module victim_cache_swap import vcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] request_address,
	input  logic [31:0] incoming_address,
	input  logic        incoming_dirty,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [31:0] returned_address,
	output logic        returned_dirty
);

	// input register
	logic  valid_s1;
	addr_t req_s1;
	addr_t inc_s1;
	logic  inc_dirty_s1;

	// result register
	logic  out_valid_q;
	kind_t kind_q;
	addr_t ret_addr_q;
	logic  ret_dirty_q;

	logic                           advance;
	lookup_t                        lk;
	logic [ENTRIES-1:0][ADDR_W-1:0] entry_addr;
	logic [ENTRIES-1:0]             entry_valid;
	logic [ENTRIES-1:0]             entry_dirty;
	logic [ENTRIES-1:0][WAY_W-1:0]  entry_age;

	// advance the held item once the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1       <= request_address;
			inc_s1       <= incoming_address;
			inc_dirty_s1 <= incoming_dirty;
		end
	end

	vcs_lookup u_lookup (
		.req_addr    (req_s1),
		.entry_addr  (entry_addr),
		.entry_valid (entry_valid),
		.entry_dirty (entry_dirty),
		.entry_age   (entry_age),
		.lk          (lk)
	);

	// entries change only when the item actually moves into the result register
	vcs_entries u_entries (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      (advance),
		.upd_way     (lk.way),
		.inc_addr    (inc_s1),
		.inc_dirty   (inc_dirty_s1),
		.entry_addr  (entry_addr),
		.entry_valid (entry_valid),
		.entry_dirty (entry_dirty),
		.entry_age   (entry_age)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q      <= lk.kind;
			ret_addr_q  <= lk.ret_addr;
			ret_dirty_q <= lk.ret_dirty;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign returned_address = ret_addr_q;
	assign returned_dirty   = ret_dirty_q;

endmodule

### rtl/vcs_lookup.sv
// Lookup logic: match search, LRU way select and result formation.
// Depends on vcs_pkg.
module vcs_lookup import vcs_pkg::*; (
	input  addr_t                    req_addr,
	input  logic [ENTRIES-1:0][ADDR_W-1:0] entry_addr,
	input  logic [ENTRIES-1:0]       entry_valid,
	input  logic [ENTRIES-1:0]       entry_dirty,
	input  logic [ENTRIES-1:0][WAY_W-1:0]  entry_age,
	output lookup_t                  lk
);

	logic  hit;
	way_t  hit_way;
	way_t  lru_way;
	way_t  way;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		lru_way = '0;
		// scan downward so the lowest matching index wins
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (entry_valid[i] && entry_addr[i] == req_addr) begin
				hit     = 1'b1;
				hit_way = way_t'(i);
			end
			if (entry_age[i] == way_t'(ENTRIES - 1)) begin
				lru_way = way_t'(i);
			end
		end
	end

	assign way = hit ? hit_way : lru_way;

	always_comb begin
		lk.way = way;
		if (hit) begin
			lk.kind      = KIND_HIT;
			lk.ret_addr  = entry_addr[way];
			lk.ret_dirty = entry_dirty[way];
		end else if (entry_valid[way] && entry_dirty[way]) begin
			lk.kind      = KIND_WRITEBACK;
			lk.ret_addr  = entry_addr[way];
			lk.ret_dirty = 1'b0;
		end else begin
			lk.kind      = KIND_MISS;
			lk.ret_addr  = '0;
			lk.ret_dirty = 1'b0;
		end
	end

endmodule

### rtl/vcs_entries.sv
// Entry storage: addresses, valid and dirty marks, LRU ages and their update.
// Depends on vcs_pkg.
module vcs_entries import vcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     upd_en,
	input  way_t                     upd_way,
	input  addr_t                    inc_addr,
	input  logic                     inc_dirty,
	output logic [ENTRIES-1:0][ADDR_W-1:0] entry_addr,
	output logic [ENTRIES-1:0]       entry_valid,
	output logic [ENTRIES-1:0]       entry_dirty,
	output logic [ENTRIES-1:0][WAY_W-1:0]  entry_age
);

	logic [ENTRIES-1:0][ADDR_W-1:0] addr_q;
	logic [ENTRIES-1:0]             valid_q;
	logic [ENTRIES-1:0]             dirty_q;
	logic [ENTRIES-1:0][WAY_W-1:0]  age_q;
	way_t                           old_age;

	assign old_age = age_q[upd_way];

	always_ff @(posedge clk) begin
		if (upd_en) begin
			addr_q[upd_way] <= inc_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= way_t'(i);
			end
		end else if (upd_en) begin
			valid_q[upd_way] <= 1'b1;
			dirty_q[upd_way] <= inc_dirty;
			// age everything younger than the touched way, then make it MRU
			for (int i = 0; i < ENTRIES; i++) begin
				if (way_t'(i) == upd_way) begin
					age_q[i] <= '0;
				end else if (age_q[i] < old_age) begin
					age_q[i] <= age_q[i] + way_t'(1);
				end
			end
		end
	end

	assign entry_addr  = addr_q;
	assign entry_valid = valid_q;
	assign entry_dirty = dirty_q;
	assign entry_age   = age_q;

endmodule

### rtl/victim_cache_swap_chk.sv
// Port-level checker for the victim buffer and its bind to the top level.
// Depends on vcs_pkg and victim_cache_swap.
module victim_cache_swap_chk import vcs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [31:0] returned_address,
	input logic        returned_dirty
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its address
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(returned_address))
		else $error("result address changed while stalled");

	// a clean miss returns nothing
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_MISS |-> returned_address == '0 && !returned_dirty)
		else $error("clean miss returned data");

	// a write-back never carries a dirty mark back to the main cache
	a_wb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_WRITEBACK |-> !returned_dirty)
		else $error("write-back result has dirty mark");

endmodule

bind victim_cache_swap victim_cache_swap_chk u_chk (.*);
